@@ hw/rtl/apn_pkg.sv @@
// ----------------------------------------------------------------------------
// apn_pkg
// Shared types and constants of the animation phase normalizer.
// ----------------------------------------------------------------------------
package apn_pkg;

    // Default build parameters.
    localparam int TIME_BITS_DEF     = 16;
    localparam int FRACTION_BITS_DEF = 16;

    // Fixed field widths.
    localparam int DELTA_W    = 16;
    localparam int DUR_W      = 16;
    localparam int ELAPSED_W  = 16;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IN_TDATA_W = 16;

    // Play modes.
    localparam logic [MODE_W-1:0] MODE_ONCE     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOOP     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PINGPONG = 2'd2;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PLAY_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DURATION  = 2'd1;

    // Register reset values.
    localparam logic [MODE_W-1:0] MODE_RESET     = MODE_ONCE;
    localparam logic [DUR_W-1:0]  DURATION_RESET = 16'd1000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic cap_in;
        logic pre;
        logic div_step;
        logic post;
        logic load_out;
    } t_apn_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_div;
        logic div_last;
        logic out_free;
    } t_apn_status;

endpackage

@@ hw/rtl/apn_ctrl.sv @@
// ----------------------------------------------------------------------------
// apn_ctrl
// Sequencer that steps one transaction through update, divide and output.
// ----------------------------------------------------------------------------
module apn_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  apn_pkg::t_apn_status i_status,
    output apn_pkg::t_apn_cmd    o_cmd
);
    import apn_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRE,
        ST_DIV1,
        ST_POST,
        ST_DIV2,
        ST_LOAD
    } t_state;

    t_state r_state;
    logic   r_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_s_tvalid && r_in_ready) begin
                        r_state    <= ST_PRE;
                        r_in_ready <= 1'b0;
                    end
                end
                ST_PRE: begin
                    r_state <= i_status.need_div ? ST_DIV1 : ST_DIV2;
                end
                ST_DIV1: begin
                    if (i_status.div_last) begin
                        r_state <= ST_POST;
                    end
                end
                ST_POST: begin
                    r_state <= ST_DIV2;
                end
                ST_DIV2: begin
                    if (i_status.div_last) begin
                        r_state <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    if (i_status.out_free) begin
                        r_state    <= ST_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state    <= ST_IDLE;
                    r_in_ready <= 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.cap_in   = (r_state == ST_IDLE) && i_s_tvalid && r_in_ready;
        o_cmd.pre      = (r_state == ST_PRE);
        o_cmd.div_step = (r_state == ST_DIV1) || (r_state == ST_DIV2);
        o_cmd.post     = (r_state == ST_POST);
        o_cmd.load_out = (r_state == ST_LOAD) && i_status.out_free;
    end

    assign o_s_tready = r_in_ready;

endmodule

@@ hw/rtl/apn_datapath.sv @@
// ----------------------------------------------------------------------------
// apn_datapath
// Elapsed-time state, mode update logic, shared restoring divider and the
// output register.
// ----------------------------------------------------------------------------
module apn_datapath #(
    parameter int TIME_BITS     = apn_pkg::TIME_BITS_DEF,
    parameter int FRACTION_BITS = apn_pkg::FRACTION_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  apn_pkg::t_apn_cmd             i_cmd,
    output apn_pkg::t_apn_status          o_status,
    input  logic                          i_cfg_we,
    input  logic [apn_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [apn_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [apn_pkg::DELTA_W-1:0]   i_delta_ticks,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [FRACTION_BITS:0]        o_phase,
    output logic [apn_pkg::ELAPSED_W-1:0] o_elapsed_ticks,
    output logic                          o_going_backward
);
    import apn_pkg::*;

    localparam int TW = TIME_BITS;
    localparam int FB = FRACTION_BITS;
    localparam int NW = TIME_BITS + FRACTION_BITS;
    localparam int CW = $clog2(NW + 1);

    logic [MODE_W-1:0]  r_mode;
    logic [DUR_W-1:0]   r_dur;
    logic [TW-1:0]      r_elapsed;
    logic               r_backward;
    logic [TW-1:0]      r_delta;
    logic               r_from_top;
    logic [TW-1:0]      r_rem;
    logic [NW-1:0]      r_num;
    logic [FB:0]        r_quo;
    logic [CW-1:0]      r_cnt;
    logic               r_out_valid;
    logic [FB:0]        r_out_phase;
    logic [ELAPSED_W-1:0] r_out_elapsed;
    logic               r_out_back;

    logic [TW-1:0] d_raw;
    logic [TW-1:0] d_eff;
    logic [TW:0]   dd;
    logic [TW-1:0] e_cur;
    logic [TW:0]   sum;

    logic [TW-1:0] pre_e;
    logic          pre_back;
    logic          pre_div;
    logic          pre_top;
    logic [TW:0]   pre_num;

    logic [TW:0]   trial;
    logic          trial_ge;
    logic [TW:0]   trial_diff;

    logic [TW-1:0] part;
    logic [TW-1:0] post_e;
    logic          post_back;

    assign d_raw = TW'(r_dur);
    assign d_eff = (d_raw == '0) ? TW'(1) : d_raw;
    assign dd    = {1'b0, d_eff};
    assign e_cur = (r_elapsed > d_eff) ? d_eff : r_elapsed;
    assign sum   = {1'b0, e_cur} + {1'b0, r_delta};

    // Step update; a bounce or a wrap past the end is finished after the
    // first division.
    always_comb begin
        pre_e    = e_cur;
        pre_back = r_backward;
        pre_div  = 1'b0;
        pre_top  = 1'b0;
        pre_num  = '0;
        case (r_mode)
            MODE_ONCE: begin
                pre_e = (sum > dd) ? d_eff : TW'(sum);
            end
            MODE_LOOP: begin
                if (sum > dd) begin
                    pre_div = 1'b1;
                    pre_num = sum - (TW+1)'(1);
                end else begin
                    pre_e = TW'(sum);
                end
            end
            MODE_PINGPONG: begin
                if (r_delta != '0) begin
                    if (!r_backward) begin
                        if (sum <= dd) begin
                            pre_e = TW'(sum);
                        end else begin
                            pre_div = 1'b1;
                            pre_top = 1'b1;
                            pre_num = sum - dd - (TW+1)'(1);
                        end
                    end else begin
                        if (r_delta <= e_cur) begin
                            pre_e = e_cur - r_delta;
                        end else begin
                            pre_div = 1'b1;
                            pre_num = {1'b0, r_delta} - {1'b0, e_cur} - (TW+1)'(1);
                        end
                    end
                end
            end
            default: begin
                pre_e = e_cur;
            end
        endcase
    end

    // One quotient bit per cycle.
    assign trial      = {r_rem, r_num[NW-1]};
    assign trial_ge   = (trial >= dd);
    assign trial_diff = trial - dd;

    // Finish a wrap or a bounce from the remainder and the quotient parity.
    always_comb begin
        part      = r_rem + TW'(1);
        post_e    = part;
        post_back = r_backward;
        if (r_mode != MODE_LOOP) begin
            if (r_from_top ^ r_quo[0]) begin
                post_e    = d_eff - part;
                post_back = 1'b1;
            end else begin
                post_e    = part;
                post_back = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_RESET;
            r_dur       <= DURATION_RESET;
            r_elapsed   <= '0;
            r_backward  <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_index == REG_PLAY_MODE || i_cfg_index == REG_DURATION)) begin
                if (i_cfg_index == REG_PLAY_MODE) begin
                    r_mode <= i_cfg_data[MODE_W-1:0];
                end else begin
                    r_dur <= i_cfg_data[DUR_W-1:0];
                end
                r_elapsed  <= '0;
                r_backward <= 1'b0;
            end
            if (i_cmd.pre) begin
                r_elapsed  <= pre_e;
                r_backward <= pre_back;
                r_rem      <= '0;
                r_quo      <= '0;
                if (pre_div) begin
                    r_num <= {pre_num, (FB-1)'(0)};
                    r_cnt <= CW'(TW + 1);
                end else begin
                    r_num <= {pre_e, FB'(0)};
                    r_cnt <= CW'(NW);
                end
            end
            if (i_cmd.div_step) begin
                r_rem <= trial_ge ? TW'(trial_diff) : TW'(trial);
                r_num <= r_num << 1;
                r_quo <= {r_quo[FB-1:0], trial_ge};
                r_cnt <= r_cnt - CW'(1);
            end
            if (i_cmd.post) begin
                r_elapsed  <= post_e;
                r_backward <= post_back;
                r_rem      <= '0;
                r_quo      <= '0;
                r_num      <= {post_e, FB'(0)};
                r_cnt      <= CW'(NW);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_delta <= TW'(i_delta_ticks);
        end
        if (i_cmd.pre) begin
            r_from_top <= pre_top;
        end
        if (i_cmd.load_out) begin
            r_out_phase   <= r_quo;
            r_out_elapsed <= ELAPSED_W'(r_elapsed);
            r_out_back    <= r_backward;
        end
    end

    always_comb begin
        o_status          = '0;
        o_status.need_div = pre_div;
        o_status.div_last = (r_cnt == CW'(1));
        o_status.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid      = r_out_valid;
    assign o_phase          = r_out_phase;
    assign o_elapsed_ticks  = r_out_elapsed;
    assign o_going_backward = r_out_back;

endmodule

@@ hw/rtl/animation_phase_normalizer_unit.sv @@
// ----------------------------------------------------------------------------
// animation_phase_normalizer_unit
// Advances an animation clock by a tick step per transaction and reports the
// phase elapsed/duration as unsigned Q1.FRACTION_BITS, with elapsed ticks and
// the ping-pong direction. Modes: play once and clamp, loop, ping-pong.
// Input stream: one transaction carries delta_ticks. Output stream: one
// transaction per input with phase, elapsed_ticks and going_backward.
// Configuration channel: index 0 writes play_mode, index 1 duration_ticks;
// any such write restarts the clock at zero going forward. Write only while
// the block is idle.
// Flow: one transaction at a time. Each result passes the update, the
// shared restoring divider, one quotient bit per cycle, and the output
// register; a wrap or bounce adds a first division and a finish step. The
// input is ready again once the result is loaded into the output register.
// Reset sets mode once, duration 1000, elapsed zero, forward direction.
// A stalled receiver holds the result in the output register; the next input
// is accepted, but its result waits until the register is free.
// ----------------------------------------------------------------------------
module animation_phase_normalizer_unit #(
    parameter int TIME_BITS     = apn_pkg::TIME_BITS_DEF,
    parameter int FRACTION_BITS = apn_pkg::FRACTION_BITS_DEF,
    localparam int OUT_FIELDS_W = FRACTION_BITS + 1 + apn_pkg::ELAPSED_W + 1,
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input stream. tdata: delta_ticks[15:0].
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [apn_pkg::IN_TDATA_W-1:0] i_s_tdata,
    // Output stream. tdata from bit 0 up: phase[FRACTION_BITS:0],
    // elapsed_ticks[15:0], going_backward, zero fill.
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [OUT_TDATA_W-1:0]         o_m_tdata,
    // Configuration write channel.
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [apn_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [apn_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import apn_pkg::*;

    t_apn_cmd              cmd;
    t_apn_status           status;
    logic [FRACTION_BITS:0] phase;
    logic [ELAPSED_W-1:0]  elapsed_ticks;
    logic                  going_backward;

    // Registers are always writable; writes are expected only while idle.
    assign o_cfg_ready = 1'b1;

    apn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    apn_datapath #(
        .TIME_BITS     (TIME_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_delta_ticks    (i_s_tdata[DELTA_W-1:0]),
        .i_out_ready      (i_m_tready),
        .o_out_valid      (o_m_tvalid),
        .o_phase          (phase),
        .o_elapsed_ticks  (elapsed_ticks),
        .o_going_backward (going_backward)
    );

    // Pack the result fields, lowest field first, zero filled to bytes.
    assign o_m_tdata = OUT_TDATA_W'({going_backward, elapsed_ticks, phase});

`ifndef NO_ASSERTIONS
    localparam logic [FRACTION_BITS:0] PHASE_ONE = (FRACTION_BITS + 1)'(1) << FRACTION_BITS;

    // The block works on one transaction at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted while a transaction is in progress");

    // Elapsed never passes the duration, so the phase never passes one.
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (phase <= PHASE_ONE))
        else $error("phase above one");

    // Zero elapsed time gives zero phase.
    a_zero_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && elapsed_ticks == '0) |-> (phase == '0))
        else $error("nonzero phase at zero elapsed time");

    // A result is only loaded when the output register is free.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!o_m_tvalid || i_m_tready))
        else $error("output register overwritten");
`endif

endmodule

@@ bench/apn_phase_checker.sv @@
// ----------------------------------------------------------------------------
// apn_phase_checker
// Watches the configuration, input and output channels of the animation phase
// normalizer, predicts every result from its own copy of the clock state and
// compares each output transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module apn_phase_checker #(
    parameter int OUT_W = 40
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [apn_pkg::IN_TDATA_W-1:0] i_s_tdata,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [OUT_W-1:0]               i_m_tdata,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [apn_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [apn_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);

    import apn_pkg::*;

    localparam int PHASE_W = FRACTION_BITS_DEF + 1;

    // Highest field first, so that phase lands in the lowest bits as on tdata.
    typedef struct packed {
        logic                 backward;
        logic [ELAPSED_W-1:0] elapsed;
        logic [PHASE_W-1:0]   phase;
    } t_phase_result;

    logic [MODE_W-1:0]    play_mode;
    logic [DUR_W-1:0]     duration;
    logic [ELAPSED_W-1:0] elapsed_now;
    logic                 going_back;

    t_phase_result expected_results[$];
    t_phase_result want;
    t_phase_result got;

    // Advances the predicted clock by one step and returns the result it gives.
    function automatic t_phase_result advance_clock(input logic [DELTA_W-1:0] delta);
        longint unsigned d;
        longint unsigned e;
        longint unsigned sum;
        longint unsigned left;
        longint unsigned passes;
        longint unsigned part;
        logic            bounce;
        logic            from_top;
        logic            odd;
        t_phase_result   r;
        d      = (duration == '0) ? 1 : duration;
        e      = elapsed_now;
        bounce = 1'b0;
        left   = 0;
        from_top = 1'b0;
        if (e > d) begin
            e = d;
        end
        case (play_mode)
            MODE_ONCE: begin
                sum = e + delta;
                e   = (sum > d) ? d : sum;
            end
            MODE_LOOP: begin
                sum = e + delta;
                if (sum > d) begin
                    sum = ((sum - 1) % d) + 1;
                end
                e = sum;
            end
            MODE_PINGPONG: begin
                if (delta != '0) begin
                    if (!going_back) begin
                        sum = e + delta;
                        if (sum <= d) begin
                            e = sum;
                        end else begin
                            left     = sum - d;
                            from_top = 1'b1;
                            bounce   = 1'b1;
                        end
                    end else if (delta <= e) begin
                        e = e - delta;
                    end else begin
                        left   = delta - e;
                        bounce = 1'b1;
                    end
                end
            end
            default: begin
                // The unused mode holds elapsed time and direction.
            end
        endcase
        if (bounce) begin
            // Whole passes swallowed by the leftover time, then the partial one.
            passes = (left - 1) / d;
            part   = left - passes * d;
            odd    = passes[0];
            if (from_top ? !odd : odd) begin
                e          = d - part;
                going_back = 1'b1;
            end else begin
                e          = part;
                going_back = 1'b0;
            end
        end
        elapsed_now = e[ELAPSED_W-1:0];
        r.phase     = PHASE_W'((e << FRACTION_BITS_DEF) / d);
        r.elapsed   = e[ELAPSED_W-1:0];
        r.backward  = going_back;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            play_mode    = MODE_RESET;
            duration     = DURATION_RESET;
            elapsed_now  = '0;
            going_back   = 1'b0;
            o_fail_count = 0;
            expected_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = t_phase_result'(i_m_tdata[PHASE_W+ELAPSED_W:0]);
                if (expected_results.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected result, expected none, actual phase %0d elapsed %0d backward %0b",
                             $time, got.phase, got.elapsed, got.backward);
                end else begin
                    want = expected_results.pop_front();
                    if (got.phase !== want.phase) begin
                        o_fail_count++;
                        $display("%0t: phase mismatch, expected %0d, actual %0d",
                                 $time, want.phase, got.phase);
                    end
                    if (got.elapsed !== want.elapsed) begin
                        o_fail_count++;
                        $display("%0t: elapsed_ticks mismatch, expected %0d, actual %0d",
                                 $time, want.elapsed, got.elapsed);
                    end
                    if (got.backward !== want.backward) begin
                        o_fail_count++;
                        $display("%0t: going_backward mismatch, expected %0b, actual %0b",
                                 $time, want.backward, got.backward);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_PLAY_MODE: begin
                        play_mode   = i_cfg_data[MODE_W-1:0];
                        elapsed_now = '0;
                        going_back  = 1'b0;
                    end
                    REG_DURATION: begin
                        duration    = i_cfg_data[DUR_W-1:0];
                        elapsed_now = '0;
                        going_back  = 1'b0;
                    end
                    default: begin
                        // Unmapped indexes change nothing.
                    end
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_results.push_back(advance_clock(i_s_tdata[DELTA_W-1:0]));
            end
        end
        o_pending = expected_results.size();
    end

endmodule

@@ bench/animation_phase_normalizer_unit_tb.sv @@
// ----------------------------------------------------------------------------
// animation_phase_normalizer_unit_tb
// Drives tick steps into the animation phase normalizer through a sequence of
// play mode and duration settings, first a directed set of boundary steps and
// then random phases, with random gaps and stalls on both streams. A separate
// checker predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module animation_phase_normalizer_unit_tb;

    import apn_pkg::*;

    localparam int OUT_TDATA_W = ((FRACTION_BITS_DEF + 1 + ELAPSED_W + 1 + 7) / 8) * 8;

    // Mode and register codes that the package leaves unnamed.
    localparam logic [MODE_W-1:0]    MODE_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RESERVED = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    localparam int RANDOM_STEPS = 1100;
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off to fill the block
    localparam int IDLE_SETTLE  = 4;     // cycles after the last result before a write
    localparam int DRAIN_CYCLES = 60;    // above the worst-case step latency
    localparam int CYCLE_LIMIT  = 600000;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    int fail_count;
    int pending;
    int steps_sent;
    int results_taken;
    int cycle_count = 0;

    animation_phase_normalizer_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    apn_phase_checker #(
        .OUT_W (OUT_TDATA_W)
    ) checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Sends one tick step. The gap before it is drawn per transaction, except in
    // a quiet stretch where the sender offers back to back. The valid stays high
    // after the handshake so that a following step with no gap is not broken up.
    task automatic send_step(input logic [DELTA_W-1:0] delta);
        int gap;
        gap = (steps_sent >= 300 && steps_sent < 400) ? 0 : $urandom_range(0, 4);
        repeat (gap) begin
            @(negedge i_clk);
            s_tvalid = 1'b0;
        end
        @(negedge i_clk);
        s_tvalid = 1'b1;
        s_tdata  = delta;
        do @(posedge i_clk); while (!s_tready);
        steps_sent++;
    endtask

    // A register write is allowed only while the block is idle. Since every step
    // yields exactly one result, an empty prediction store plus a few cycles
    // means the block has nothing left in flight.
    task automatic wait_idle();
        @(negedge i_clk);
        s_tvalid = 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (IDLE_SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        wait_idle();
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    // The mode sits in the low bits; the upper bits are noise the block ignores.
    task automatic write_mode(input logic [MODE_W-1:0] mode);
        write_reg(REG_PLAY_MODE, {(CFG_DATA_W - MODE_W)'($urandom), mode});
    endtask

    // Steps are biased toward the interesting range around the duration, so
    // clamping, wrapping and multi-bounce reflection all come up often.
    function automatic logic [DELTA_W-1:0] pick_delta(input logic [DUR_W-1:0] dur);
        int d;
        int pick;
        d    = (dur == '0) ? 1 : int'(dur);
        pick = $urandom_range(0, 9);
        case (pick)
            0:       return '0;
            1:       return '1;
            2, 3, 4: return DELTA_W'($urandom_range(0, d));
            5, 6:    return DELTA_W'($urandom_range(0, (3 * d > 65535) ? 65535 : 3 * d));
            7:       return DELTA_W'($urandom_range(d - 1, (d + 1 > 65535) ? 65535 : d + 1));
            default: return DELTA_W'($urandom);
        endcase
    endfunction

    // Receiver: a random hold-off before each transaction, quiet stretches with
    // none, and now and then a long hold-off while the sender keeps offering, so
    // the output register fills and the input side has to stall.
    initial begin
        int wait_cycles;
        m_tready      = 1'b0;
        results_taken = 0;
        @(posedge i_rst_n);
        forever begin
            if (results_taken == 100 || results_taken == 400 || results_taken == 800) begin
                repeat (HOLD_CYCLES) begin
                    @(negedge i_clk);
                    m_tready = 1'b0;
                end
            end
            wait_cycles = (results_taken >= 300 && results_taken < 400) ? 0
                        : $urandom_range(0, 4);
            repeat (wait_cycles) begin
                @(negedge i_clk);
                m_tready = 1'b0;
            end
            @(negedge i_clk);
            m_tready = 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
            results_taken++;
        end
    end

    // Stimulus and verdict.
    initial begin
        int                  random_steps;
        int                  phase_steps;
        int                  pick;
        logic [MODE_W-1:0]   mode;
        logic [DUR_W-1:0]    dur;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_PLAY_MODE;
        cfg_data   = '0;
        steps_sent = 0;
        i_rst_n    = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings, play once over 1000 ticks: a zero step, an exact
        // landing on the duration, then clamping.
        send_step(16'd0);
        send_step(16'd500);
        send_step(16'd499);
        send_step(16'd1);
        send_step(16'd1);
        send_step(16'hFFFF);

        // Loop: coming to rest exactly at the duration, then wrapping.
        write_mode(MODE_LOOP);
        send_step(16'd1000);
        send_step(16'd1);
        send_step(16'd2999);
        send_step(16'hFFFF);
        send_step(16'd0);

        // Ping-pong over 7 ticks: exact top stays forward, leftover flips it,
        // exact zero stays backward, then a long multi-bounce step.
        write_reg(REG_DURATION, 16'd7);
        write_mode(MODE_PINGPONG);
        send_step(16'd7);
        send_step(16'd3);
        send_step(16'd4);
        send_step(16'd1);
        send_step(16'd0);
        send_step(16'hFFFF);

        // The unused mode holds still, here with a zero duration as well.
        write_reg(REG_DURATION, 16'd0);
        write_mode(MODE_UNUSED);
        send_step(16'd5);
        send_step(16'd0);

        // Ping-pong at the largest duration, with a write to an unmapped index
        // in between that must not restart the clock.
        write_mode(MODE_PINGPONG);
        write_reg(REG_DURATION, 16'hFFFF);
        send_step(16'hFFFF);
        write_reg(REG_UNMAPPED, 16'($urandom));
        send_step(16'hFFFF);
        send_step(16'd1);

        // Ping-pong with a zero duration, which acts as one tick.
        write_reg(REG_DURATION, 16'd0);
        write_reg(REG_RESERVED, 16'($urandom));
        send_step(16'd2);
        send_step(16'd1);
        send_step(16'd0);

        // Random phases: new settings, then a run of steps under them.
        random_steps = 0;
        while (random_steps < RANDOM_STEPS) begin
            pick = $urandom_range(0, 19);
            if (pick < 6) begin
                mode = MODE_ONCE;
            end else if (pick < 12) begin
                mode = MODE_LOOP;
            end else if (pick < 19) begin
                mode = MODE_PINGPONG;
            end else begin
                mode = MODE_UNUSED;
            end
            case ($urandom_range(0, 5))
                0:       dur = DUR_W'($urandom_range(1, 8));
                1:       dur = DUR_W'($urandom_range(1, 64));
                2:       dur = DUR_W'($urandom_range(1, 2000));
                3:       dur = DUR_W'($urandom);
                4:       dur = '1;
                default: dur = DUR_W'($urandom_range(0, 1));
            endcase
            if ($urandom_range(0, 7) == 0) begin
                write_reg($urandom_range(0, 1) ? REG_RESERVED : REG_UNMAPPED, 16'($urandom));
            end
            if ($urandom_range(0, 1)) begin
                write_mode(mode);
                write_reg(REG_DURATION, dur);
            end else begin
                write_reg(REG_DURATION, dur);
                write_mode(mode);
            end
            phase_steps = $urandom_range(10, 50);
            repeat (phase_steps) begin
                send_step(pick_delta(dur));
            end
            random_steps += phase_steps;
        end

        @(negedge i_clk);
        s_tvalid = 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ animation_phase_normalizer_unit.f @@
hw/rtl/apn_pkg.sv
hw/rtl/apn_ctrl.sv
hw/rtl/apn_datapath.sv
hw/rtl/animation_phase_normalizer_unit.sv
bench/apn_phase_checker.sv
bench/animation_phase_normalizer_unit_tb.sv
